>>> design/qmn_pkg.sv
// shared widths and types for the normalized quaternion product
package qmn_pkg;

   localparam int FRAC_BITS_DEF = 14;

   localparam int CW    = 16;          // component width
   localparam int PW    = 2 * CW;      // one partial product
   localparam int SUMW  = PW + 2;      // signed sum of four products
   localparam int MAGW  = SUMW - 1;    // magnitude of that sum
   localparam int LEADW = 6;           // leading-one position of a magnitude
   localparam int QW    = 30;          // normalized magnitude, msb at bit 29
   localparam int QTOP  = QW - 1;
   localparam int SQW   = 2 * QW + 2;  // sum of four squares
   localparam int ROOTW = SQW / 2;     // integer square root

   typedef logic signed [SUMW-1:0] comp_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic signed [CW-1:0] w;
   } quat_type;

   typedef logic [3:0][QW-1:0] qset_type;

   // sign of each component and the all-zero flag, carried beside the data
   typedef struct packed {
      logic [3:0] neg;
      logic       zero;
   } side_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic signed [CW-1:0] w;
      logic                 zero;
   } result_type;

endpackage

>>> design/qmn_req_if.sv
// request channel carrying the two input quaternions
interface qmn_req_if;
   logic                valid;
   logic                ready;
   logic signed [15:0]  a_x;
   logic signed [15:0]  a_y;
   logic signed [15:0]  a_z;
   logic signed [15:0]  a_w;
   logic signed [15:0]  b_x;
   logic signed [15:0]  b_y;
   logic signed [15:0]  b_z;
   logic signed [15:0]  b_w;

   modport source (output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, input ready);
   modport sink (input valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, output ready);
endinterface

>>> design/qmn_rsp_if.sv
// response channel carrying the normalized product
interface qmn_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [15:0]  r_x;
   logic signed [15:0]  r_y;
   logic signed [15:0]  r_z;
   logic signed [15:0]  r_w;
   logic                zero_product;

   modport source (output valid, r_x, r_y, r_z, r_w, zero_product, input ready);
   modport sink (input valid, r_x, r_y, r_z, r_w, zero_product, output ready);
endinterface

>>> design/qmn_product.sv
// hamilton product b times a: partial products, then signed sums
module qmn_product (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  qmn_pkg::quat_type a,
   input  qmn_pkg::quat_type b,
   output logic              out_valid,
   output qmn_pkg::comp_type p_out [4]
);
   import qmn_pkg::*;

   logic signed [PW-1:0] t_ff [4][4];
   logic                 valid_t_ff;
   comp_type             p_ff [4];
   logic                 valid_p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_t_ff <= 1'b0;
         valid_p_ff <= 1'b0;
      end else if (adv) begin
         valid_t_ff <= in_valid;
         valid_p_ff <= valid_t_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff[0][0] <= PW'(b.w * a.x);
         t_ff[0][1] <= PW'(b.x * a.w);
         t_ff[0][2] <= PW'(b.y * a.z);
         t_ff[0][3] <= PW'(b.z * a.y);
         t_ff[1][0] <= PW'(b.w * a.y);
         t_ff[1][1] <= PW'(b.y * a.w);
         t_ff[1][2] <= PW'(b.z * a.x);
         t_ff[1][3] <= PW'(b.x * a.z);
         t_ff[2][0] <= PW'(b.w * a.z);
         t_ff[2][1] <= PW'(b.z * a.w);
         t_ff[2][2] <= PW'(b.x * a.y);
         t_ff[2][3] <= PW'(b.y * a.x);
         t_ff[3][0] <= PW'(b.w * a.w);
         t_ff[3][1] <= PW'(b.x * a.x);
         t_ff[3][2] <= PW'(b.y * a.y);
         t_ff[3][3] <= PW'(b.z * a.z);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= SUMW'(t_ff[i][0]) + SUMW'(t_ff[i][1]) + SUMW'(t_ff[i][2])
                       - SUMW'(t_ff[i][3]);
         end
         p_ff[3] <= SUMW'(t_ff[3][0]) - SUMW'(t_ff[3][1]) - SUMW'(t_ff[3][2])
                    - SUMW'(t_ff[3][3]);
      end
   end

   assign out_valid = valid_p_ff;
   assign p_out     = p_ff;

endmodule

>>> design/qmn_norm.sv
// magnitudes, common shift to put the largest at bit 29, sum of squares
module qmn_norm (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  qmn_pkg::comp_type         p_in [4],
   output logic                      out_valid,
   output logic [qmn_pkg::SQW-1:0]   s_out,
   output qmn_pkg::qset_type         q_out,
   output qmn_pkg::side_type         side_out
);
   import qmn_pkg::*;

   logic [3:0][MAGW-1:0] mag_a_ff, mag_b_ff;
   logic [3:0]           neg_a_ff;
   side_type             side_b_ff, side_c_ff, side_d_ff, side_e_ff;
   logic [LEADW-1:0]     lead_b_ff;
   qset_type             q_c_ff, q_d_ff, q_e_ff;
   logic [3:0][2*QW-1:0] sq_d_ff;
   logic [SQW-1:0]       s_e_ff;
   logic [4:0]           valid_ff;

   logic [MAGW-1:0]      or_all;
   logic [LEADW-1:0]     lead_in;
   qset_type             q_in;
   logic [MAGW-1:0]      shifted [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   // leading one of the largest equals leading one of the or of all
   always_comb begin
      or_all  = mag_a_ff[0] | mag_a_ff[1] | mag_a_ff[2] | mag_a_ff[3];
      lead_in = '0;
      for (int i = 0; i < MAGW; i++) begin
         if (or_all[i]) begin
            lead_in = LEADW'(i);
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         if (lead_b_ff >= LEADW'(QTOP)) begin
            shifted[l] = mag_b_ff[l] >> (lead_b_ff - LEADW'(QTOP));
         end else begin
            shifted[l] = mag_b_ff[l] << (LEADW'(QTOP) - lead_b_ff);
         end
         q_in[l] = shifted[l][QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 4; l++) begin
            mag_a_ff[l] <= p_in[l][SUMW-1] ? MAGW'(-p_in[l]) : MAGW'(p_in[l]);
            neg_a_ff[l] <= p_in[l][SUMW-1];
            sq_d_ff[l]  <= (2*QW)'(q_c_ff[l] * q_c_ff[l]);
         end
         mag_b_ff       <= mag_a_ff;
         lead_b_ff      <= lead_in;
         side_b_ff.neg  <= neg_a_ff;
         side_b_ff.zero <= (or_all == '0);
         q_c_ff         <= q_in;
         side_c_ff      <= side_b_ff;
         q_d_ff         <= q_c_ff;
         side_d_ff      <= side_c_ff;
         s_e_ff         <= SQW'(sq_d_ff[0]) + SQW'(sq_d_ff[1]) + SQW'(sq_d_ff[2])
                           + SQW'(sq_d_ff[3]);
         q_e_ff         <= q_d_ff;
         side_e_ff      <= side_d_ff;
      end
   end

   assign out_valid = valid_ff[4];
   assign s_out     = s_e_ff;
   assign q_out     = q_e_ff;
   assign side_out  = side_e_ff;

endmodule

>>> design/qmn_sqrt.sv
// pipelined integer square root, one result bit per stage
module qmn_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  logic [qmn_pkg::SQW-1:0]   s_in,
   input  qmn_pkg::qset_type         q_in,
   input  qmn_pkg::side_type         side_in,
   output logic                      out_valid,
   output logic [qmn_pkg::ROOTW-1:0] n_out,
   output qmn_pkg::qset_type         q_out,
   output qmn_pkg::side_type         side_out
);
   import qmn_pkg::*;

   logic [SQW-1:0] v_ff     [ROOTW];
   logic [SQW-1:0] res_ff   [ROOTW];
   qset_type       q_ff     [ROOTW];
   side_type       side_ff  [ROOTW];
   logic [ROOTW-1:0] valid_ff;

   logic [SQW-1:0] v_src    [ROOTW];
   logic [SQW-1:0] res_src  [ROOTW];
   qset_type       q_src    [ROOTW];
   side_type       side_src [ROOTW];
   logic           valid_src [ROOTW];
   logic [SQW-1:0] v_in     [ROOTW];
   logic [SQW-1:0] res_in   [ROOTW];

   for (genvar k = 0; k < ROOTW; k++) begin : g_stage
      localparam logic [SQW-1:0] Bit = SQW'(1) << (SQW - 2 - 2 * k);
      logic [SQW-1:0] trial;

      if (k == 0) begin : g_first
         assign v_src[k]     = s_in;
         assign res_src[k]   = '0;
         assign q_src[k]     = q_in;
         assign side_src[k]  = side_in;
         assign valid_src[k] = in_valid;
      end else begin : g_next
         assign v_src[k]     = v_ff[k-1];
         assign res_src[k]   = res_ff[k-1];
         assign q_src[k]     = q_ff[k-1];
         assign side_src[k]  = side_ff[k-1];
         assign valid_src[k] = valid_ff[k-1];
      end

      always_comb begin
         trial = res_src[k] + Bit;
         if (v_src[k] >= trial) begin
            v_in[k]   = v_src[k] - trial;
            res_in[k] = (res_src[k] >> 1) + Bit;
         end else begin
            v_in[k]   = v_src[k];
            res_in[k] = res_src[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            v_ff[k]    <= v_in[k];
            res_ff[k]  <= res_in[k];
            q_ff[k]    <= q_src[k];
            side_ff[k] <= side_src[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOTW-1];
   assign n_out     = res_ff[ROOTW-1][ROOTW-1:0];
   assign q_out     = q_ff[ROOTW-1];
   assign side_out  = side_ff[ROOTW-1];

endmodule

>>> design/qmn_div.sv
// four-lane restoring divider, rounded half up, one quotient bit per stage
module qmn_div #(
   parameter int FRAC_BITS = qmn_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  qmn_pkg::qset_type          q_in,
   input  logic [qmn_pkg::ROOTW-1:0]  n_in,
   input  qmn_pkg::side_type          side_in,
   output logic                       out_valid,
   output logic [3:0][FRAC_BITS:0]    quo_out,
   output qmn_pkg::side_type          side_out
);
   import qmn_pkg::*;

   localparam int QBITS = FRAC_BITS + 1;
   localparam int NUMW  = QW + FRAC_BITS + 1;

   logic [3:0][NUMW-1:0]  num_ff;
   logic [ROOTW-1:0]      n_p_ff;
   side_type              side_p_ff;
   logic                  valid_p_ff;

   logic [3:0][NUMW-1:0]  rem_ff  [QBITS];
   logic [3:0][QBITS-1:0] quo_ff  [QBITS];
   logic [ROOTW-1:0]      n_ff    [QBITS];
   side_type              side_ff [QBITS];
   logic [QBITS-1:0]      valid_ff;

   logic [3:0][NUMW-1:0]  rem_src  [QBITS];
   logic [3:0][QBITS-1:0] quo_src  [QBITS];
   logic [ROOTW-1:0]      n_src    [QBITS];
   side_type              side_src [QBITS];
   logic                  valid_src [QBITS];
   logic [3:0][NUMW-1:0]  rem_in   [QBITS];
   logic [3:0][QBITS-1:0] quo_in   [QBITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_p_ff <= 1'b0;
      end else if (adv) begin
         valid_p_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 4; l++) begin
            num_ff[l] <= (NUMW'(q_in[l]) << FRAC_BITS) + NUMW'(n_in >> 1);
         end
         n_p_ff    <= n_in;
         side_p_ff <= side_in;
      end
   end

   for (genvar k = 0; k < QBITS; k++) begin : g_stage
      logic [NUMW-1:0] d;

      if (k == 0) begin : g_first
         assign rem_src[k]   = num_ff;
         assign quo_src[k]   = '0;
         assign n_src[k]     = n_p_ff;
         assign side_src[k]  = side_p_ff;
         assign valid_src[k] = valid_p_ff;
      end else begin : g_next
         assign rem_src[k]   = rem_ff[k-1];
         assign quo_src[k]   = quo_ff[k-1];
         assign n_src[k]     = n_ff[k-1];
         assign side_src[k]  = side_ff[k-1];
         assign valid_src[k] = valid_ff[k-1];
      end

      assign d = NUMW'(n_src[k]) << (FRAC_BITS - k);

      always_comb begin
         for (int l = 0; l < 4; l++) begin
            if (rem_src[k][l] >= d) begin
               rem_in[k][l] = rem_src[k][l] - d;
               quo_in[k][l] = {quo_src[k][l][QBITS-2:0], 1'b1};
            end else begin
               rem_in[k][l] = rem_src[k][l];
               quo_in[k][l] = {quo_src[k][l][QBITS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in[k];
            quo_ff[k]  <= quo_in[k];
            n_ff[k]    <= n_src[k];
            side_ff[k] <= side_src[k];
         end
      end
   end

   assign out_valid = valid_ff[QBITS-1];
   assign quo_out   = quo_ff[QBITS-1];
   assign side_out  = side_ff[QBITS-1];

endmodule

>>> design/quaternion_multiply_normalize.sv
// Normalized quaternion product r = b * a in signed fixed point, scaled to unit
// length; 1.0 is 2^FRAC_BITS at the output. One beat is taken every cycle while the
// response side keeps up. Each beat passes through products and sums, normalizing
// and sum of squares, square root at one root bit per stage, division at one
// quotient bit per stage, and the output register. A skid register lets one more
// beat in while a result waits; a zero product returns (0,0,0,1.0)
// with zero_product set.
module quaternion_multiply_normalize #(
   parameter int FRAC_BITS = qmn_pkg::FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   qmn_req_if.sink    req,
   qmn_rsp_if.source  rsp
);
   import qmn_pkg::*;

   localparam int QBITS = FRAC_BITS + 1;
   localparam int VW    = QBITS + 1;
   localparam logic [QBITS-1:0] One = QBITS'(1) << FRAC_BITS;

   logic               adv;
   quat_type           a, b;
   logic               prod_valid;
   comp_type           p [4];
   logic               norm_valid;
   logic [SQW-1:0]     s;
   qset_type           q_norm, q_root;
   side_type           side_norm, side_root, side_div;
   logic               root_valid;
   logic [ROOTW-1:0]   n;
   logic               div_valid;
   logic [3:0][FRAC_BITS:0] quo;

   result_type         res;
   result_type         out_ff, skid_ff;
   logic               out_valid_ff, skid_valid_ff;
   logic signed [CW-1:0] comp [4];
   logic [QBITS-1:0]   sat;

   function automatic logic signed [CW-1:0] fit(input logic signed [VW-1:0] v);
      logic signed [CW-1:0] r;
      if (v > 32767) begin
         r = 16'sh7fff;
      end else if (v < -32768) begin
         r = 16'sh8000;
      end else begin
         r = CW'(v);
      end
      return r;
   endfunction

   assign adv       = !skid_valid_ff;
   assign req.ready = adv;

   assign a = '{x: req.a_x, y: req.a_y, z: req.a_z, w: req.a_w};
   assign b = '{x: req.b_x, y: req.b_y, z: req.b_z, w: req.b_w};

   qmn_product u_product (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req.valid),
      .a         (a),
      .b         (b),
      .out_valid (prod_valid),
      .p_out     (p)
   );

   qmn_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (prod_valid),
      .p_in      (p),
      .out_valid (norm_valid),
      .s_out     (s),
      .q_out     (q_norm),
      .side_out  (side_norm)
   );

   qmn_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (norm_valid),
      .s_in      (s),
      .q_in      (q_norm),
      .side_in   (side_norm),
      .out_valid (root_valid),
      .n_out     (n),
      .q_out     (q_root),
      .side_out  (side_root)
   );

   qmn_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (root_valid),
      .q_in      (q_root),
      .n_in      (n),
      .side_in   (side_root),
      .out_valid (div_valid),
      .quo_out   (quo),
      .side_out  (side_div)
   );

   // saturate to 1.0, apply sign, clamp into the 16-bit field
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         sat = (quo[l] > One) ? One : quo[l];
         if (side_div.neg[l]) begin
            comp[l] = fit(-$signed({1'b0, sat}));
         end else begin
            comp[l] = fit($signed({1'b0, sat}));
         end
      end
      if (side_div.zero) begin
         res.x    = '0;
         res.y    = '0;
         res.z    = '0;
         res.w    = fit($signed({1'b0, One}));
         res.zero = 1'b1;
      end else begin
         res.x    = comp[0];
         res.y    = comp[1];
         res.z    = comp[2];
         res.w    = comp[3];
         res.zero = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_valid_ff && !rsp.ready) begin
         if (div_valid && adv) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         out_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_ff && !rsp.ready) begin
         if (adv) begin
            skid_ff <= res;
         end
      end else if (skid_valid_ff) begin
         out_ff <= skid_ff;
      end else begin
         out_ff <= res;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.r_x          = out_ff.x;
   assign rsp.r_y          = out_ff.y;
   assign rsp.r_z          = out_ff.z;
   assign rsp.r_w          = out_ff.w;
   assign rsp.zero_product = out_ff.zero;

endmodule
